// ===== hw/rtl/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher block.
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int KEY_DEPTH  = 256;
  localparam int CNT_W      = 9;

  // Key bytes past this count are dropped.
  localparam logic [CNT_W-1:0] MAX_KEY_BYTES = 9'd256;

  typedef enum logic [1:0] {
    OP_KEY,
    OP_KEY_LAST,
    OP_DATA
  } rc4_op_t;

  typedef struct packed {
    rc4_op_t           op;
    logic [BYTE_W-1:0] data;
    logic              last;
  } rc4_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_D_J,
    ST_D_T,
    ST_D_OUT,
    ST_K_RD,
    ST_K_J,
    ST_K_WN,
    ST_K_WJ
  } rc4_state_t;

endpackage

// ===== hw/rtl/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rc4_front.sv =====
// Input side: classifies requests and buffers them in a two-entry queue.
module rc4_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_mode,
  input  logic [rc4_pkg::BYTE_W-1:0] in_byte_in,
  input  logic                     in_last,
  output logic                     q_valid,
  output rc4_pkg::rc4_item_t       q_item,
  input  logic                     q_pop
);

  rc4_pkg::rc4_item_t entry_r [2];
  logic               wptr_r, wptr_nxt;
  logic               rptr_r, rptr_nxt;
  logic [1:0]         count_r, count_nxt;
  logic               push;
  logic               pop;
  rc4_pkg::rc4_item_t new_item;

  assign in_stall = (count_r == 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = entry_r[rptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    new_item.data = in_byte_in;
    new_item.last = in_last;
    priority if (in_mode) begin
      new_item.op = rc4_pkg::OP_DATA;
    end else if (in_last) begin
      new_item.op = rc4_pkg::OP_KEY_LAST;
    end else begin
      new_item.op = rc4_pkg::OP_KEY;
    end
  end

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/rc4_back.sv =====
// Execution side: key store, key schedule, keystream generation and result register.
module rc4_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  rc4_pkg::rc4_item_t         q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rc4_pkg::BYTE_W-1:0] out_byte_out,
  output logic                       out_end_of_message
);

  localparam int AW = $clog2(rc4_pkg::PERM_DEPTH);
  localparam int KW = $clog2(rc4_pkg::KEY_DEPTH);
  localparam int BW = rc4_pkg::BYTE_W;
  localparam int CW = rc4_pkg::CNT_W;

  rc4_pkg::rc4_state_t state_r, state_nxt;

  logic [BW-1:0] i_r, i_nxt;
  logic [BW-1:0] j_r, j_nxt;
  logic [BW-1:0] jj_r, jj_nxt;
  logic [BW-1:0] si_r, si_nxt;
  logic [BW-1:0] sj_r, sj_nxt;
  logic [BW-1:0] t_r, t_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic [KW-1:0] kidx_r, kidx_nxt;
  logic [CW-1:0] key_count_r, key_count_nxt;
  logic          key_complete_r, key_complete_nxt;
  logic [BW-1:0] byte_r, byte_nxt;
  logic          eom_r, eom_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] out_byte_r, out_byte_nxt;
  logic          out_eom_r, out_eom_nxt;

  logic [rc4_pkg::PERM_DEPTH-1:0] perm_vld_r;
  logic                           pv_rd_r;
  logic [AW-1:0]                  ra_r;
  logic                           vld_clr;

  logic          p_we;
  logic [AW-1:0] p_waddr, p_raddr;
  logic [BW-1:0] p_wdata, p_rdata;
  logic          k_we;
  logic [KW-1:0] k_waddr, k_raddr;
  logic [BW-1:0] k_wdata, k_rdata;

  logic [BW-1:0] s_rd;
  logic [BW-1:0] ks;
  logic [CW-1:0] cnt_base;
  logic          out_free;

  rc4_ram #(.WIDTH(BW), .DEPTH(rc4_pkg::PERM_DEPTH)) u_perm (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(.WIDTH(BW), .DEPTH(rc4_pkg::KEY_DEPTH)) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  // An entry never written since the last identity reset reads as its own index.
  assign s_rd     = pv_rd_r ? p_rdata : ra_r;
  assign cnt_base = key_complete_r ? '0 : key_count_r;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_byte_out       = out_byte_r;
  assign out_end_of_message = out_eom_r;

  // Keystream byte as seen after the swap.
  always_comb begin
    priority if (t_r == i_r) begin
      ks = sj_r;
    end else if (t_r == j_r) begin
      ks = si_r;
    end else begin
      ks = s_rd;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    jj_nxt           = jj_r;
    si_nxt           = si_r;
    sj_nxt           = sj_r;
    t_nxt            = t_r;
    n_nxt            = n_r;
    kidx_nxt         = kidx_r;
    key_count_nxt    = key_count_r;
    key_complete_nxt = key_complete_r;
    byte_nxt         = byte_r;
    eom_nxt          = eom_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_byte_nxt     = out_byte_r;
    out_eom_nxt      = out_eom_r;
    q_pop            = 1'b0;
    vld_clr          = 1'b0;
    p_we             = 1'b0;
    p_waddr          = '0;
    p_wdata          = '0;
    p_raddr          = '0;
    k_we             = 1'b0;
    k_waddr          = cnt_base[KW-1:0];
    k_wdata          = q_item.data;
    k_raddr          = kidx_r;

    unique case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            rc4_pkg::OP_DATA: begin
              i_nxt     = i_r + 8'd1;
              p_raddr   = i_nxt;
              byte_nxt  = q_item.data;
              eom_nxt   = q_item.last;
              state_nxt = rc4_pkg::ST_D_J;
            end
            rc4_pkg::OP_KEY, rc4_pkg::OP_KEY_LAST: begin
              key_count_nxt = cnt_base;
              if (cnt_base < rc4_pkg::MAX_KEY_BYTES) begin
                k_we          = 1'b1;
                key_count_nxt = cnt_base + 9'd1;
              end
              key_complete_nxt = (q_item.op == rc4_pkg::OP_KEY_LAST);
              if (q_item.op == rc4_pkg::OP_KEY_LAST) begin
                // Restart from identity and run the schedule.
                vld_clr   = 1'b1;
                i_nxt     = '0;
                j_nxt     = '0;
                jj_nxt    = '0;
                n_nxt     = '0;
                kidx_nxt  = '0;
                state_nxt = rc4_pkg::ST_K_RD;
              end
            end
            default: begin
              state_nxt = rc4_pkg::ST_IDLE;
            end
          endcase
        end
      end

      rc4_pkg::ST_D_J: begin
        si_nxt    = s_rd;
        j_nxt     = j_r + s_rd;
        p_raddr   = j_nxt;
        state_nxt = rc4_pkg::ST_D_T;
      end

      rc4_pkg::ST_D_T: begin
        sj_nxt    = s_rd;
        p_we      = 1'b1;
        p_waddr   = j_r;
        p_wdata   = si_r;
        t_nxt     = si_r + s_rd;
        p_raddr   = t_nxt;
        state_nxt = rc4_pkg::ST_D_OUT;
      end

      rc4_pkg::ST_D_OUT: begin
        p_we    = 1'b1;
        p_waddr = i_r;
        p_wdata = sj_r;
        p_raddr = t_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = byte_r ^ ks;
          out_eom_nxt   = eom_r;
          // Chain straight into the next data request.
          if (q_valid && (q_item.op == rc4_pkg::OP_DATA)) begin
            q_pop     = 1'b1;
            i_nxt     = i_r + 8'd1;
            p_raddr   = i_nxt;
            byte_nxt  = q_item.data;
            eom_nxt   = q_item.last;
            state_nxt = rc4_pkg::ST_D_J;
          end else begin
            state_nxt = rc4_pkg::ST_IDLE;
          end
        end
      end

      rc4_pkg::ST_K_RD: begin
        p_raddr   = n_r;
        k_raddr   = kidx_r;
        state_nxt = rc4_pkg::ST_K_J;
      end

      rc4_pkg::ST_K_J: begin
        si_nxt    = s_rd;
        jj_nxt    = jj_r + k_rdata + s_rd;
        p_raddr   = jj_nxt;
        state_nxt = rc4_pkg::ST_K_WN;
      end

      rc4_pkg::ST_K_WN: begin
        p_we      = 1'b1;
        p_waddr   = n_r;
        p_wdata   = s_rd;
        state_nxt = rc4_pkg::ST_K_WJ;
      end

      rc4_pkg::ST_K_WJ: begin
        p_we    = 1'b1;
        p_waddr = jj_r;
        p_wdata = si_r;
        n_nxt   = n_r + 8'd1;
        if (({1'b0, kidx_r} + 9'd1) >= key_count_r) begin
          kidx_nxt = '0;
        end else begin
          kidx_nxt = kidx_r + 8'd1;
        end
        if (n_r == 8'hff) begin
          state_nxt = rc4_pkg::ST_IDLE;
        end else begin
          state_nxt = rc4_pkg::ST_K_RD;
        end
      end

      default: begin
        state_nxt = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_vld_r <= '0;
    end else if (vld_clr) begin
      perm_vld_r <= '0;
    end else if (p_we) begin
      perm_vld_r[p_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pv_rd_r    <= perm_vld_r[p_raddr];
    ra_r       <= p_raddr;
    jj_r       <= jj_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    t_r        <= t_nxt;
    n_r        <= n_nxt;
    kidx_r     <= kidx_nxt;
    byte_r     <= byte_nxt;
    eom_r      <= eom_nxt;
    out_byte_r <= out_byte_nxt;
    out_eom_r  <= out_eom_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= rc4_pkg::ST_IDLE;
      i_r            <= '0;
      j_r            <= '0;
      key_count_r    <= '0;
      key_complete_r <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      i_r            <= i_nxt;
      j_r            <= j_nxt;
      key_count_r    <= key_count_nxt;
      key_complete_r <= key_complete_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/rc4_stream_cipher.sv =====
// RC4 stream cipher top level: input queue in front, cipher engine behind it.
// Data byte: ST_D_J, ST_D_T, then ST_D_OUT, which loads the result register when free;
//   ST_D_OUT pops the next data byte as it loads the result and chains into ST_D_J.
// Key byte: stored; the last one adds the key schedule, each step ST_K_RD to ST_K_WJ.
// Reset (rst_n low, synchronous): queue empty, no result pending, permutation identity,
//   i = j = 0, next key byte starts a new key.
module rc4_stream_cipher (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic [rc4_pkg::BYTE_W-1:0] in_byte_in,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rc4_pkg::BYTE_W-1:0] out_byte_out,
  output logic                       out_end_of_message
);

  logic               q_valid;
  logic               q_pop;
  rc4_pkg::rc4_item_t q_item;

  rc4_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_byte_in (in_byte_in),
    .in_last    (in_last),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  rc4_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_out       (out_byte_out),
    .out_end_of_message (out_end_of_message)
  );

endmodule

// ===== hw/rtl/rc4_checker.sv =====
// Port-level checks for the RC4 stream cipher, bound to the top level.
module rc4_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_mode,
  input logic [rc4_pkg::BYTE_W-1:0] in_byte_in,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rc4_pkg::BYTE_W-1:0] out_byte_out,
  input logic                       out_end_of_message
);

  logic [2:0] pending_r, pending_nxt;
  logic       data_in;
  logic       res_out;

  assign data_in = in_valid && !in_stall && in_mode;
  assign res_out = out_valid && !out_stall;
  assign pending_nxt = pending_r + {2'b00, data_in} - {2'b00, res_out};

  // Track data requests whose result has not been taken yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_mode) && $stable(in_byte_in)
                             && $stable(in_last))
    else $error("request changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_out)
                               && $stable(out_end_of_message))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result without a pending data request");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd4)
    else $error("more data requests in flight than buffering allows");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear the channels");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);

// ===== verif/rc4_stream_cipher_tb.sv =====
// Self-checking testbench for the RC4 stream cipher block.
`timescale 1ns / 100ps

module rc4_stream_cipher_tb;

  localparam int BYTE_W     = rc4_pkg::BYTE_W;
  localparam int PERM_DEPTH = rc4_pkg::PERM_DEPTH;
  localparam int KEY_DEPTH  = rc4_pkg::KEY_DEPTH;
  localparam int CNT_W      = rc4_pkg::CNT_W;
  localparam logic [CNT_W-1:0] MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES;

  localparam bit MODE_KEY  = 1'b0;
  localparam bit MODE_DATA = 1'b1;

  localparam int NUM_REQUESTS = 700;
  localparam int QUIET_TAIL   = 100;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 64;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct {
    bit                mode;
    logic [BYTE_W-1:0] data_byte;
    bit                last;
    bit                drain_first;
  } cipher_req_t;

  typedef struct {
    logic [BYTE_W-1:0] data_byte;
    logic              eom;
  } cipher_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_mode = MODE_KEY;
  logic [BYTE_W-1:0] in_byte_in = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte_out;
  logic              out_end_of_message;

  cipher_req_t request_queue[$];
  cipher_res_t expected_results[$];

  // Cipher state as predicted from the accepted requests
  logic [BYTE_W-1:0] perm_tbl[PERM_DEPTH];
  logic [BYTE_W-1:0] key_mem[KEY_DEPTH];
  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;
  logic [CNT_W-1:0]  key_len;
  bit                key_closed;

  int          mismatches = 0;
  int          results_seen = 0;
  int unsigned cycle_count = 0;

  rc4_stream_cipher uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_byte_in         (in_byte_in),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_out       (out_byte_out),
    .out_end_of_message (out_end_of_message)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_cipher_state();
    for (int n = 0; n < PERM_DEPTH; n++) perm_tbl[n[BYTE_W-1:0]] = n[BYTE_W-1:0];
    idx_i = '0;
    idx_j = '0;
    key_len = '0;
    key_closed = 1'b1;
  endfunction

  // Key schedule over the bytes stored for the current key
  function automatic void schedule_key();
    logic [CNT_W-1:0]  kidx;
    logic [BYTE_W-1:0] jj;
    logic [BYTE_W-1:0] t;
    for (int n = 0; n < PERM_DEPTH; n++) perm_tbl[n[BYTE_W-1:0]] = n[BYTE_W-1:0];
    idx_i = '0;
    idx_j = '0;
    kidx = '0;
    jj = '0;
    for (int n = 0; n < PERM_DEPTH; n++) begin
      t = perm_tbl[n[BYTE_W-1:0]];
      jj = jj + key_mem[kidx[BYTE_W-1:0]] + t;
      perm_tbl[n[BYTE_W-1:0]] = perm_tbl[jj];
      perm_tbl[jj] = t;
      kidx = kidx + 1'b1;
      if (kidx >= key_len) kidx = '0;
    end
  endfunction

  function automatic void apply_request(input cipher_req_t rq);
    logic [BYTE_W-1:0] si;
    logic [BYTE_W-1:0] sj;
    logic [BYTE_W-1:0] ks_idx;
    cipher_res_t       res;
    if (rq.mode == MODE_KEY) begin
      if (key_closed) begin
        key_len = '0;
        key_closed = 1'b0;
      end
      // drop key bytes once the store is full
      if (key_len < MAX_KEY_BYTES) begin
        key_mem[key_len[BYTE_W-1:0]] = rq.data_byte;
        key_len = key_len + 1'b1;
      end
      if (rq.last) begin
        schedule_key();
        key_closed = 1'b1;
      end
    end else begin
      idx_i = idx_i + 1'b1;
      si = perm_tbl[idx_i];
      idx_j = idx_j + si;
      sj = perm_tbl[idx_j];
      perm_tbl[idx_j] = si;
      perm_tbl[idx_i] = sj;
      ks_idx = si + sj;
      res.data_byte = rq.data_byte ^ perm_tbl[ks_idx];
      res.eom = rq.last;
      expected_results.push_back(res);
    end
  endfunction

  function automatic void push_req(input bit mode, input logic [BYTE_W-1:0] value,
                                   input bit last, input bit drain_first);
    cipher_req_t rq;
    rq.mode = mode;
    rq.data_byte = value;
    rq.last = last;
    rq.drain_first = drain_first;
    request_queue.push_back(rq);
  endfunction

  function automatic void add_key(input int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      push_req(MODE_KEY, BYTE_W'($urandom), k == len - 1, 1'b0);
  endfunction

  function automatic void add_message(input int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      push_req(MODE_DATA, BYTE_W'($urandom), k == len - 1,
               k == 0 && $urandom_range(0, 19) == 0);
  endfunction

  task automatic build_stimulus();
    int unsigned kind;
    int unsigned n;
    bit          overlong_done;
    bit          full_key_done;
    // keystream of the identity permutation before any key
    push_req(MODE_DATA, 8'h00, 1'b0, 1'b0);
    push_req(MODE_DATA, 8'hff, 1'b1, 1'b0);
    push_req(MODE_DATA, 8'ha5, 1'b0, 1'b0);
    push_req(MODE_KEY,  8'h00, 1'b1, 1'b0);
    push_req(MODE_DATA, 8'hff, 1'b0, 1'b0);
    push_req(MODE_DATA, 8'h00, 1'b1, 1'b0);
    push_req(MODE_KEY,  8'hff, 1'b0, 1'b0);
    push_req(MODE_KEY,  8'h80, 1'b0, 1'b0);
    push_req(MODE_KEY,  8'h01, 1'b1, 1'b0);
    push_req(MODE_DATA, 8'h5a, 1'b0, 1'b1);
    push_req(MODE_DATA, 8'hc3, 1'b0, 1'b0);
    push_req(MODE_DATA, 8'h7e, 1'b1, 1'b0);
    // data in the middle of a key load uses the old permutation
    push_req(MODE_KEY,  8'h5a, 1'b0, 1'b0);
    push_req(MODE_DATA, 8'h3c, 1'b0, 1'b0);
    push_req(MODE_DATA, 8'h81, 1'b1, 1'b0);
    push_req(MODE_KEY,  8'hc3, 1'b1, 1'b0);
    push_req(MODE_DATA, 8'h00, 1'b0, 1'b0);
    push_req(MODE_DATA, 8'hff, 1'b1, 1'b0);
    push_req(MODE_KEY,  8'h7f, 1'b0, 1'b0);
    push_req(MODE_KEY,  8'hfe, 1'b1, 1'b0);
    push_req(MODE_DATA, 8'h01, 1'b1, 1'b1);

    overlong_done = 1'b0;
    full_key_done = 1'b0;
    while (request_queue.size() < NUM_REQUESTS) begin
      if (!overlong_done && request_queue.size() > 100) begin
        add_key(260);
        add_message(8);
        overlong_done = 1'b1;
      end else if (!full_key_done && request_queue.size() > 450) begin
        add_key(KEY_DEPTH);
        add_message(8);
        full_key_done = 1'b1;
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
          add_key(n);
          add_message($urandom_range(1, 40));
        end else if (kind < 85) begin
          repeat ($urandom_range(1, 12))
            push_req(MODE_DATA, BYTE_W'($urandom), 1'($urandom_range(0, 1)), 1'b0);
        end else if (kind < 93) begin
          n = $urandom_range(1, 10);
          for (int unsigned k = 0; k < n; k++) begin
            push_req(MODE_KEY, BYTE_W'($urandom), k == n - 1, 1'b0);
            if ($urandom_range(0, 2) == 0)
              push_req(MODE_DATA, BYTE_W'($urandom), 1'($urandom_range(0, 1)), 1'b0);
          end
        end else begin
          repeat ($urandom_range(1, 6))
            push_req(1'($urandom_range(0, 1)), BYTE_W'($urandom),
                     1'($urandom_range(0, 1)), 1'b0);
        end
      end
    end
  endtask

  // Driver
  int unsigned send_gap = 0;
  int unsigned send_idle_pct = 0;

  always @(posedge clk) begin
    cipher_req_t rq;
    bit          fire;
    bit          quiet;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        rq.mode = in_mode;
        rq.data_byte = in_byte_in;
        rq.last = in_last;
        rq.drain_first = 1'b0;
        apply_request(rq);
      end
      quiet = request_queue.size() < QUIET_TAIL;
      if ($urandom_range(0, 63) == 0) send_idle_pct = 5 * $urandom_range(0, 4);
      if (!in_valid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (request_queue[0].drain_first && expected_results.size() != 0) begin
          // hold until every outstanding result is back
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else begin
          rq = request_queue.pop_front();
          in_valid <= 1'b1;
          in_mode <= rq.mode;
          in_byte_in <= rq.data_byte;
          in_last <= rq.last;
        end
      end
    end
  end

  // Monitor and result-side backpressure
  int unsigned hold_left = 0;
  int unsigned recv_idle_pct = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk) begin
    cipher_res_t exp_res;
    bit          quiet;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result %02h eom %0b with no request outstanding",
                     $realtime, out_byte_out, out_end_of_message);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_byte_out !== exp_res.data_byte || out_end_of_message !== exp_res.eom) begin
            if (mismatches < 10)
              $display("%0t: mismatch byte_out exp %02h got %02h, eom exp %0b got %0b",
                       $realtime, exp_res.data_byte, out_byte_out, exp_res.eom,
                       out_end_of_message);
            mismatches++;
          end
        end
      end
      quiet = request_queue.size() < QUIET_TAIL;
      if ($urandom_range(0, 63) == 0) recv_idle_pct = 5 * $urandom_range(0, 4);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= 120) begin
        // back up the block until it stalls its input
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
        hold_left = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[rc4_stream_cipher] ERROR");
    $finish;
  end

  initial begin
    build_stimulus();
    clear_cipher_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (request_queue.size() != 0 || in_valid);
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[rc4_stream_cipher] OK");
    end else begin
      $display("[rc4_stream_cipher] ERROR");
    end
    $finish;
  end

endmodule
